// ===== rtl/vna_pkg.sv =====
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int ACCUM_BITS_DEF   = 32;

  localparam int IDX_W   = 12;
  localparam int POS_W   = 32;
  localparam int NRM_W   = 16;
  localparam int CMD_W   = 2;
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 64;

  // unit length in q1.14
  localparam logic [14:0] Q14_ONE = 15'd16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIVI,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } norm_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRI_RA,
    S_TRI_RB,
    S_TRI_RC,
    S_TRI_EDGE,
    S_NAB_GO,
    S_NAB_WAIT,
    S_NAC_GO,
    S_NAC_WAIT,
    S_CROSS_MUL,
    S_CROSS_RND,
    S_ACC_RD,
    S_ACC_WR,
    S_RD_ACC,
    S_RD_GO,
    S_RD_WAIT
  } state_t;

endpackage

// ===== rtl/vna_norm.sv =====
module vna_norm #(
  parameter int NW = 33
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2:0][NW-1:0]                vec,
  output vna_pkg::norm_stat_t               stat,
  output logic [2:0][vna_pkg::NRM_W-1:0]    res
);

  vna_pkg::norm_state_t nstate, nstate_next;

  logic [2:0]          neg;
  logic [2:0][NW-1:0]  m;
  logic [NW-1:0]       mx;
  logic [2:0]          step;
  logic [1:0]          idx;
  logic [61:0]         sumsq;
  logic [61:0]         num;
  logic [61:0]         root;
  logic [61:0]         sbit;
  logic [30:0]         rem;
  logic [14:0]         nb;
  logic [14:0]         q;
  logic [3:0]          cnt;
  logic                zero_r;

  logic [2:0][NW-1:0]  mag_in;
  logic [NW-1:0]       mx_in;
  logic [4:0]          sh;
  logic                go_right;
  logic                go_left;
  logic [59:0]         prod;
  logic [61:0]         sumsq_next;
  logic [61:0]         trial;
  logic [30:0]         len;
  logic [44:0]         dvd;
  logic [31:0]         r2;
  logic                ge;
  logic [14:0]         q_new;
  logic [14:0]         q_clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = vec[k][NW-1] ? (~vec[k] + NW'(1)) : vec[k];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
    sh       = 5'(5'd1 << step);
    go_right = 64'(mx) >= (64'd1 << (29 + int'(sh)));
    go_left  = 64'(mx) < (64'd1 << (30 - int'(sh)));
    prod       = m[idx][29:0] * m[idx][29:0];
    sumsq_next = sumsq + 62'(prod);
    trial      = root + sbit;
    len        = root[30:0];
    dvd        = 45'({m[idx][29:0], 14'd0}) + 45'(len >> 1);
    r2         = {rem, nb[14]};
    ge         = r2 >= {1'b0, len};
    q_new      = {q[13:0], ge};
    q_clip     = (q_new > vna_pkg::Q14_ONE) ? vna_pkg::Q14_ONE : q_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nstate <= vna_pkg::N_IDLE;
    end else begin
      nstate <= nstate_next;
    end
  end

  always_comb begin
    nstate_next = nstate;
    case (nstate)
      vna_pkg::N_IDLE: begin
        if (start) nstate_next = (mx_in == '0) ? vna_pkg::N_DONE : vna_pkg::N_SHIFT;
      end
      vna_pkg::N_SHIFT: begin
        if (step == 3'd0) nstate_next = vna_pkg::N_SQ;
      end
      vna_pkg::N_SQ: begin
        if (idx == 2'd2) nstate_next = vna_pkg::N_SQRT;
      end
      vna_pkg::N_SQRT: begin
        if (sbit == 62'd1) nstate_next = vna_pkg::N_DIVI;
      end
      vna_pkg::N_DIVI: nstate_next = vna_pkg::N_DIV;
      vna_pkg::N_DIV: begin
        if (cnt == 4'd1) nstate_next = (idx == 2'd2) ? vna_pkg::N_DONE : vna_pkg::N_DIVI;
      end
      vna_pkg::N_DONE: nstate_next = vna_pkg::N_IDLE;
      default: nstate_next = vna_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (nstate)
      vna_pkg::N_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= vec[k][NW-1];
          end
          m      <= mag_in;
          mx     <= mx_in;
          step   <= 3'd4;
          zero_r <= (mx_in == '0);
          if (mx_in == '0) res <= '0;
        end
      end
      vna_pkg::N_SHIFT: begin
        // greedy binary steps bring the largest magnitude into [2^29, 2^30)
        if (go_right) begin
          mx <= mx >> sh;
          for (int k = 0; k < 3; k++) m[k] <= m[k] >> sh;
        end else if (go_left) begin
          mx <= mx << sh;
          for (int k = 0; k < 3; k++) m[k] <= m[k] << sh;
        end
        step  <= step - 3'd1;
        idx   <= 2'd0;
        sumsq <= '0;
      end
      vna_pkg::N_SQ: begin
        sumsq <= sumsq_next;
        idx   <= idx + 2'd1;
        if (idx == 2'd2) begin
          num  <= sumsq_next;
          root <= '0;
          sbit <= 62'd1 << 60;
        end
      end
      vna_pkg::N_SQRT: begin
        if (num >= trial) begin
          num  <= num - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        sbit <= sbit >> 2;
        idx  <= 2'd0;
      end
      vna_pkg::N_DIVI: begin
        rem <= 31'(dvd[44:15]);
        nb  <= dvd[14:0];
        q   <= '0;
        cnt <= 4'd15;
      end
      vna_pkg::N_DIV: begin
        rem <= ge ? 31'(r2 - {1'b0, len}) : r2[30:0];
        nb  <= {nb[13:0], 1'b0};
        q   <= q_new;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          res[idx] <= neg[idx] ? (~{1'b0, q_clip} + 16'd1) : {1'b0, q_clip};
          idx      <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.busy = (nstate != vna_pkg::N_IDLE);
    stat.done = (nstate == vna_pkg::N_DONE);
    stat.zero = zero_r;
  end

endmodule

// ===== rtl/vertex_normal_accumulation.sv =====
// Smooth vertex normals over a mesh held in two on-chip memories (positions and
// normal sums, one entry per vertex). Command 0 (load) clears the vertex's sum;
// commands 1 (triangle) and 2 (read) spend nearly all their time in the shared
// normalizer, whose square root retires one result bit per cycle and whose
// divider one quotient bit per cycle.
// Sums are updated one corner at a time by read-modify-write, so a triangle with
// repeated corners is handled. A read result sits in an output register, so the
// next command is taken while it waits. Entries are meaningless until loaded.
module vertex_normal_accumulation #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int ACCUM_BITS   = vna_pkg::ACCUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // index_a, index_b, index_c, pos_x, pos_y, pos_z, zero pad
  input  logic [vna_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [vna_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // vertex_index, normal_x, normal_y, normal_z, zero pad
  output logic [vna_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // zero_normal
  output logic                          m_axis_tuser
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = (ACCUM_BITS > 33) ? ACCUM_BITS : 33;
  localparam int IW = vna_pkg::IDX_W;
  localparam int PW = vna_pkg::POS_W;

  logic [2:0][PW-1:0]         pos_mem [MAX_VERTICES];
  logic [2:0][ACCUM_BITS-1:0] acc_mem [MAX_VERTICES];

  vna_pkg::state_t state, state_next;
  vna_pkg::cmd_t   cmd;

  logic                        accept;
  logic [IW-1:0]               in_a, in_b, in_c;
  logic                        ok_a, ok_b, ok_c;
  logic [2:0][PW-1:0]          in_pos;

  logic [IW-1:0]               idx_a;
  logic [AW-1:0]               addr_a, addr_b, addr_c;
  logic [1:0]                  corner;
  logic [AW-1:0]               pos_raddr, acc_addr;
  logic [2:0][PW-1:0]          pos_rd, pa, pb;
  logic [2:0][ACCUM_BITS-1:0]  acc_rd, acc_new;
  logic [2:0][NW-1:0]          vab, vac, nvec;
  logic [2:0][15:0]            u, nres, rn;
  logic                        rzero;
  logic [5:0][31:0]            prod;
  logic [2:0][17:0]            cr;
  logic                        nstart;
  vna_pkg::norm_stat_t         nstat;
  logic                        can_load;

  logic [2:0][NW-1:0]          ab_c, ac_c;
  logic [2:0][17:0]            cr_c;
  logic [2:0][NW-1:0]          acc_ext;

  logic [IW-1:0]               out_idx;
  logic [2:0][15:0]            out_n;
  logic                        out_zero;

  assign cmd      = vna_pkg::cmd_t'(s_axis_tuser);
  assign in_a     = s_axis_tdata[11:0];
  assign in_b     = s_axis_tdata[23:12];
  assign in_c     = s_axis_tdata[35:24];
  assign in_pos   = s_axis_tdata[131:36];
  assign ok_a     = 32'(in_a) < 32'(MAX_VERTICES);
  assign ok_b     = 32'(in_b) < 32'(MAX_VERTICES);
  assign ok_c     = 32'(in_c) < 32'(MAX_VERTICES);
  assign s_axis_tready = (state == vna_pkg::S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign can_load = !m_axis_tvalid || m_axis_tready;

  vna_norm #(.NW(NW)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .vec   (nvec),
    .stat  (nstat),
    .res   (nres)
  );

  always_comb begin
    case (state)
      vna_pkg::S_TRI_RA: pos_raddr = addr_a;
      vna_pkg::S_TRI_RB: pos_raddr = addr_b;
      default:           pos_raddr = addr_c;
    endcase
    case (corner)
      2'd0:    acc_addr = addr_a;
      2'd1:    acc_addr = addr_b;
      default: acc_addr = addr_c;
    endcase

    for (int k = 0; k < 3; k++) begin
      ab_c[k] = NW'($signed({pb[k][PW-1], pb[k]} - {pa[k][PW-1], pa[k]}));
      ac_c[k] = NW'($signed({pos_rd[k][PW-1], pos_rd[k]} - {pa[k][PW-1], pa[k]}));
      acc_ext[k] = NW'($signed(acc_rd[k]));
    end

    for (int k = 0; k < 3; k++) begin
      logic [31:0] p;
      logic [31:0] pm;
      logic [17:0] r;
      p  = prod[2*k] - prod[2*k+1];
      pm = p[31] ? (~p + 32'd1) : p;
      r  = 18'((pm + 32'd8192) >> 14);
      cr_c[k] = p[31] ? (~r + 18'd1) : r;
    end

    // saturating add of the rounded cross product
    for (int k = 0; k < 3; k++) begin
      logic [ACCUM_BITS:0] s;
      s = {acc_rd[k][ACCUM_BITS-1], acc_rd[k]} + (ACCUM_BITS+1)'($signed(cr[k]));
      if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
        acc_new[k] = s[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                   : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      end else begin
        acc_new[k] = s[ACCUM_BITS-1:0];
      end
    end

    case (state)
      vna_pkg::S_NAB_GO: nvec = vab;
      vna_pkg::S_NAC_GO: nvec = vac;
      default:           nvec = acc_ext;
    endcase
    nstart = (state == vna_pkg::S_NAB_GO) || (state == vna_pkg::S_NAC_GO)
             || (state == vna_pkg::S_RD_GO);
  end

  always_ff @(posedge clk) begin
    pos_rd <= pos_mem[pos_raddr];
    acc_rd <= acc_mem[acc_addr];
    if (accept && cmd == vna_pkg::CMD_LOAD && ok_a) begin
      pos_mem[AW'(in_a)] <= in_pos;
      acc_mem[AW'(in_a)] <= '0;
    end else if (state == vna_pkg::S_ACC_WR) begin
      acc_mem[acc_addr] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vna_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vna_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd)
            vna_pkg::CMD_TRI: begin
              if (ok_a && ok_b && ok_c) state_next = vna_pkg::S_TRI_RA;
            end
            vna_pkg::CMD_READ: state_next = ok_a ? vna_pkg::S_RD_ACC : vna_pkg::S_RD_WAIT;
            default: state_next = vna_pkg::S_IDLE;
          endcase
        end
      end
      vna_pkg::S_TRI_RA:   state_next = vna_pkg::S_TRI_RB;
      vna_pkg::S_TRI_RB:   state_next = vna_pkg::S_TRI_RC;
      vna_pkg::S_TRI_RC:   state_next = vna_pkg::S_TRI_EDGE;
      vna_pkg::S_TRI_EDGE: state_next = vna_pkg::S_NAB_GO;
      vna_pkg::S_NAB_GO:   state_next = vna_pkg::S_NAB_WAIT;
      vna_pkg::S_NAB_WAIT: begin
        if (nstat.done) state_next = nstat.zero ? vna_pkg::S_IDLE : vna_pkg::S_NAC_GO;
      end
      vna_pkg::S_NAC_GO:   state_next = vna_pkg::S_NAC_WAIT;
      vna_pkg::S_NAC_WAIT: begin
        if (nstat.done) state_next = nstat.zero ? vna_pkg::S_IDLE : vna_pkg::S_CROSS_MUL;
      end
      vna_pkg::S_CROSS_MUL: state_next = vna_pkg::S_CROSS_RND;
      vna_pkg::S_CROSS_RND: state_next = vna_pkg::S_ACC_RD;
      vna_pkg::S_ACC_RD:    state_next = vna_pkg::S_ACC_WR;
      vna_pkg::S_ACC_WR: begin
        state_next = (corner == 2'd2) ? vna_pkg::S_IDLE : vna_pkg::S_ACC_RD;
      end
      vna_pkg::S_RD_ACC: state_next = vna_pkg::S_RD_GO;
      vna_pkg::S_RD_GO:  state_next = vna_pkg::S_RD_WAIT;
      // waits for the normalizer, then for room in the output register
      vna_pkg::S_RD_WAIT: begin
        if (!nstat.busy && can_load) state_next = vna_pkg::S_IDLE;
      end
      default: state_next = vna_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_a  <= in_a;
      addr_a <= AW'(in_a);
      addr_b <= AW'(in_b);
      addr_c <= AW'(in_c);
      corner <= 2'd0;
      rn     <= '0;
      rzero  <= 1'b1;
    end
    case (state)
      vna_pkg::S_TRI_RB:   pa <= pos_rd;
      vna_pkg::S_TRI_RC:   pb <= pos_rd;
      vna_pkg::S_TRI_EDGE: begin
        vab <= ab_c;
        vac <= ac_c;
      end
      vna_pkg::S_NAB_WAIT: begin
        if (nstat.done) u <= nres;
      end
      vna_pkg::S_CROSS_MUL: begin
        prod[0] <= 32'($signed(u[1]) * $signed(nres[2]));
        prod[1] <= 32'($signed(u[2]) * $signed(nres[1]));
        prod[2] <= 32'($signed(u[2]) * $signed(nres[0]));
        prod[3] <= 32'($signed(u[0]) * $signed(nres[2]));
        prod[4] <= 32'($signed(u[0]) * $signed(nres[1]));
        prod[5] <= 32'($signed(u[1]) * $signed(nres[0]));
      end
      vna_pkg::S_CROSS_RND: cr <= cr_c;
      vna_pkg::S_ACC_WR:    corner <= corner + 2'd1;
      vna_pkg::S_RD_WAIT: begin
        if (nstat.done) begin
          rn    <= nres;
          rzero <= nstat.zero;
        end
        if (!nstat.busy && can_load) begin
          out_idx  <= idx_a;
          out_n    <= rn;
          out_zero <= rzero;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == vna_pkg::S_RD_WAIT && !nstat.busy && can_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {4'd0, out_n[2], out_n[1], out_n[0], out_idx};
  assign m_axis_tuser = out_zero;

endmodule

// ===== rtl/vna_check.sv =====
module vna_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [vna_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input logic [vna_pkg::CMD_W-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vna_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[59:12] == 48'd0)
    else $error("zero normal flag with nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[27:12]) >= -16384 && $signed(m_axis_tdata[27:12]) <= 16384 &&
      $signed(m_axis_tdata[43:28]) >= -16384 && $signed(m_axis_tdata[43:28]) <= 16384 &&
      $signed(m_axis_tdata[59:44]) >= -16384 && $signed(m_axis_tdata[59:44]) <= 16384)
    else $error("normal component out of range");

endmodule

bind vertex_normal_accumulation vna_check u_vna_check (.*);

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [vna_pkg::CMD_W-1:0] CMD_NONE = 2'd3;  // unused code, dropped by the block
  localparam int VERTS = vna_pkg::MAX_VERTICES_DEF;
  localparam longint ACC_HI = (64'sd1 <<< (vna_pkg::ACCUM_BITS_DEF - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic [vna_pkg::CMD_W-1:0]  cmd;
    logic [vna_pkg::IDX_W-1:0]  ia, ib, ic;
    logic [vna_pkg::POS_W-1:0]  px, py, pz;
  } cmd_item_t;

  typedef struct {
    logic [vna_pkg::IDX_W-1:0]  vidx;
    logic [vna_pkg::NRM_W-1:0]  nx, ny, nz;
    logic                       zflag;
  } normal_t;

  typedef struct {
    cmd_item_t it;
    bit        typed;
    normal_t   res;
  } row_t;

  typedef longint vec3_t [3];

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [vna_pkg::S_DATA_W-1:0]  s_axis_tdata = '0;
  logic [vna_pkg::CMD_W-1:0]     s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [vna_pkg::M_DATA_W-1:0]  m_axis_tdata;
  logic                          m_axis_tuser;

  vertex_normal_accumulation DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  vec3_t   vert_pos [VERTS];
  vec3_t   normal_sum [VERTS];
  normal_t pending_normals [$];
  row_t    directed [$];
  int      loaded_ids [$];
  bit      is_loaded [VERTS];
  int      errors = 0;
  int      calm_items = 0;
  int      calm_beats = 0;
  int      stall_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // scale so the largest magnitude lands in [2^29, 2^30), then divide by the length
  function automatic bit to_unit(input vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned mx, len, q;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
      if (m[k] > mx) mx = m[k];
      o[k] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= 64'h4000_0000) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    while (mx < 64'h2000_0000) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) m[k] <<= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 16384 + len / 2) / len;
      if (q > 16384) q = 16384;
      o[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint q28_to_q14(input longint p);
    longint unsigned m;
    longint r;
    m = (p < 0) ? longint'(-p) : longint'(p);
    r = longint'((m + 8192) >> 14);
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint clamp_sum(input longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  function automatic void mesh_update(input cmd_item_t it, output bit has, output normal_t r);
    vec3_t ab, ac, u, w, cr, n;
    int a, b, c;
    bit ok;
    has = 0;
    r = '{default: '0};
    a = it.ia;
    b = it.ib;
    c = it.ic;
    if (it.cmd == vna_pkg::CMD_LOAD) begin
      vert_pos[a][0] = longint'(signed'(it.px));
      vert_pos[a][1] = longint'(signed'(it.py));
      vert_pos[a][2] = longint'(signed'(it.pz));
      for (int k = 0; k < 3; k++) normal_sum[a][k] = 0;
    end else if (it.cmd == vna_pkg::CMD_TRI) begin
      for (int k = 0; k < 3; k++) begin
        ab[k] = vert_pos[b][k] - vert_pos[a][k];
        ac[k] = vert_pos[c][k] - vert_pos[a][k];
      end
      // a degenerate edge leaves the sums alone
      if (to_unit(ab, u) && to_unit(ac, w)) begin
        cr[0] = q28_to_q14(u[1] * w[2] - u[2] * w[1]);
        cr[1] = q28_to_q14(u[2] * w[0] - u[0] * w[2]);
        cr[2] = q28_to_q14(u[0] * w[1] - u[1] * w[0]);
        for (int k = 0; k < 3; k++) begin
          normal_sum[a][k] = clamp_sum(normal_sum[a][k] + cr[k]);
          normal_sum[b][k] = clamp_sum(normal_sum[b][k] + cr[k]);
          normal_sum[c][k] = clamp_sum(normal_sum[c][k] + cr[k]);
        end
      end
    end else if (it.cmd == vna_pkg::CMD_READ) begin
      ok = to_unit(normal_sum[a], n);
      has = 1;
      r.vidx = it.ia;
      r.nx = n[0][vna_pkg::NRM_W-1:0];
      r.ny = n[1][vna_pkg::NRM_W-1:0];
      r.nz = n[2][vna_pkg::NRM_W-1:0];
      r.zflag = !ok;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_items = $urandom_range(10, 40);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_row(input row_t rw);
    int gap;
    bit has;
    normal_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rw.it.cmd;
    s_axis_tdata  <= {4'b0, rw.it.pz, rw.it.py, rw.it.px, rw.it.ic, rw.it.ib, rw.it.ia};
    do @(posedge clk); while (!s_axis_tready);
    mesh_update(rw.it, has, r);
    if (has) pending_normals.push_back(rw.typed ? rw.res : r);
    @(negedge clk);
  endtask

  function automatic row_t mk_row(input logic [vna_pkg::CMD_W-1:0] cmd, input int a, b, c,
                                  input logic [vna_pkg::POS_W-1:0] x, y, z);
    row_t rw;
    rw.it = '{cmd, a[vna_pkg::IDX_W-1:0], b[vna_pkg::IDX_W-1:0], c[vna_pkg::IDX_W-1:0],
              x, y, z};
    rw.typed = 0;
    rw.res = '{default: '0};
    return rw;
  endfunction

  function automatic row_t mk_read(input int a, input bit typed, input logic [15:0] nz,
                                   input bit zf);
    row_t rw;
    rw = mk_row(vna_pkg::CMD_READ, a, $urandom, $urandom, $urandom, $urandom, $urandom);
    rw.typed = typed;
    rw.res = '{a[vna_pkg::IDX_W-1:0], 16'd0, 16'd0, nz, zf};
    return rw;
  endfunction

  function automatic logic [vna_pkg::POS_W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return vna_pkg::POS_W'($urandom_range(0, 8 * 65536)) - vna_pkg::POS_W'(4 * 65536);
  endfunction

  function automatic int pool_pick();
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  // result side: random stalls on tready
  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (calm_beats > 0) begin
      calm_beats--;
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) calm_beats = $urandom_range(50, 400);
      else if (r < 25) stall_left = $urandom_range(1, 3);
      else if (r < 28) stall_left = $urandom_range(10, 80);
      m_axis_tready <= (r >= 5 && r < 28) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_axis_tdata);
        errors++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (m_axis_tdata[11:0] !== exp_n.vidx) begin
          $error("vertex_index expected %0d actual %0d", exp_n.vidx, m_axis_tdata[11:0]);
          errors++;
        end
        if (m_axis_tdata[27:12] !== exp_n.nx) begin
          $error("normal_x expected %0d actual %0d", $signed(exp_n.nx),
                 $signed(m_axis_tdata[27:12]));
          errors++;
        end
        if (m_axis_tdata[43:28] !== exp_n.ny) begin
          $error("normal_y expected %0d actual %0d", $signed(exp_n.ny),
                 $signed(m_axis_tdata[43:28]));
          errors++;
        end
        if (m_axis_tdata[59:44] !== exp_n.nz) begin
          $error("normal_z expected %0d actual %0d", $signed(exp_n.nz),
                 $signed(m_axis_tdata[59:44]));
          errors++;
        end
        if (m_axis_tuser !== exp_n.zflag) begin
          $error("zero_normal expected %0d actual %0d", exp_n.zflag, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t rw;
    int r, idx, n_random;
    for (int i = 0; i < VERTS; i++) begin
      for (int k = 0; k < 3; k++) begin
        vert_pos[i][k] = 0;
        normal_sum[i][k] = 0;
      end
      is_loaded[i] = 0;
    end

    // unit triangle in the xy plane gives +z on all corners
    directed.push_back(mk_row(vna_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_read(0, 1, 16'd0, 1));
    directed.push_back(mk_row(vna_pkg::CMD_LOAD, 1, 0, 0, 32'd65536, 0, 0));
    directed.push_back(mk_row(vna_pkg::CMD_LOAD, 2, 0, 0, 0, 32'd65536, 0));
    directed.push_back(mk_row(vna_pkg::CMD_LOAD, 4095, 4095, 4095,
                              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 0, 1, 2, $urandom, $urandom, $urandom));
    directed.push_back(mk_read(0, 1, 16'd16384, 0));
    directed.push_back(mk_read(1, 1, 16'd16384, 0));
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 0, 0, 2, 0, 0, 0));  // zero-length edge
    directed.push_back(mk_read(2, 1, 16'd16384, 0));
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 4095, 1, 2, 0, 0, 0));
    directed.push_back(mk_read(4095, 0, 0, 0));
    directed.push_back(mk_row(vna_pkg::CMD_LOAD, 3, 0, 0,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 3, 4095, 0, 0, 0, 0));
    directed.push_back(mk_read(3, 0, 0, 0));
    directed.push_back(mk_row(CMD_NONE, 4095, 4095, 4095, '1, '1, '1));
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 1, 2, 1, 0, 0, 0));  // repeated corner
    directed.push_back(mk_row(vna_pkg::CMD_TRI, 2, 1, 0, 0, 0, 0));
    directed.push_back(mk_read(0, 0, 0, 0));
    directed.push_back(mk_read(2, 0, 0, 0));
    directed.push_back(mk_read(1, 0, 0, 0));
    foreach (directed[i])
      if (directed[i].it.cmd == vna_pkg::CMD_LOAD && !is_loaded[directed[i].it.ia]) begin
        is_loaded[directed[i].it.ia] = 1;
        loaded_ids.push_back(directed[i].it.ia);
      end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_row(directed[i]);

    n_random = 480;
    for (int i = 0; i < n_random; i++) begin
      if (i == n_random / 2) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_normals.size() != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        if (loaded_ids.size() < 24 || $urandom_range(0, 3) == 0) begin
          idx = $urandom_range(0, VERTS - 1);
          if (!is_loaded[idx]) begin
            is_loaded[idx] = 1;
            loaded_ids.push_back(idx);
          end
        end else begin
          idx = pool_pick();
        end
        rw = mk_row(vna_pkg::CMD_LOAD, idx, $urandom, $urandom,
                    rand_coord(), rand_coord(), rand_coord());
      end else if (r < 72) begin
        rw = mk_row(vna_pkg::CMD_TRI, pool_pick(), pool_pick(), pool_pick(),
                    $urandom, $urandom, $urandom);
      end else if (r < 95) begin
        rw = mk_read(pool_pick(), 0, 0, 0);
      end else begin
        rw = mk_row(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_row(rw);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
